### rtl/mbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg: shared types and constants for the escape-time iteration block
// Field widths, register map, controller state and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package mbe_pkg;

  // Payload widths
  localparam int DATA_W     = 32;
  localparam int CNT_W      = 16;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] ADDR_ITER_LIMIT  = 2'd0;
  localparam logic [CNT_W-1:0]      ITER_LIMIT_RESET = 16'd120;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_HOLD
  } mbe_state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic mul;
    logic step;
    logic load_out;
  } mbe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic beyond;
    logic at_limit;
  } mbe_sts_t;

endpackage

### rtl/mbe_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_in_if: point channel
// Carries one complex point c per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mbe_in_if;
  import mbe_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] c_real;
  logic signed [DATA_W-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

### rtl/mbe_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_out_if: result channel
// Carries the iteration count, escape flag and final z per item.
// ----------------------------------------------------------------------------
interface mbe_out_if;
  import mbe_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CNT_W-1:0]         iteration_count;
  logic                     escaped;
  logic signed [DATA_W-1:0] z_real_final;
  logic signed [DATA_W-1:0] z_imag_final;

  modport source (output valid, output iteration_count, output escaped,
                  output z_real_final, output z_imag_final, input ready);
  modport sink   (input valid, input iteration_count, input escaped,
                  input z_real_final, input z_imag_final, output ready);
endinterface

### rtl/mbe_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_datapath: fixed-point z*z + c datapath
// Squares and cross product in one registered multiply step, then escape
// test, floor shift, add of c and saturation in the update step.
// ----------------------------------------------------------------------------
module mbe_datapath #(
  parameter int FRAC_BITS = 28
) (
  input  logic                             clk,
  input  logic signed [mbe_pkg::DATA_W-1:0] c_real,
  input  logic signed [mbe_pkg::DATA_W-1:0] c_imag,
  input  logic [mbe_pkg::CNT_W-1:0]        limit,
  input  mbe_pkg::mbe_cmd_t                cmd,
  output mbe_pkg::mbe_sts_t                sts,
  output logic [mbe_pkg::CNT_W-1:0]        iteration_count,
  output logic                             escaped,
  output logic signed [mbe_pkg::DATA_W-1:0] z_real_final,
  output logic signed [mbe_pkg::DATA_W-1:0] z_imag_final
);
  import mbe_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int ESC_SH = 2 * FRAC_BITS + 2;
  localparam logic ESC_EN = (ESC_SH <= PROD_W - 1);
  localparam logic [PROD_W-1:0] ESC_THR =
    ESC_EN ? (PROD_W'(1) << ESC_SH) : '0;

  // Clamp a wide signed value to the DATA_W signed range
  function automatic logic signed [DATA_W-1:0] sat_data(
    input logic signed [PROD_W-1:0] v
  );
    logic signed [DATA_W-1:0] res;
    if ((&v[PROD_W-1:DATA_W-1]) || !(|v[PROD_W-1:DATA_W-1])) begin
      res = v[DATA_W-1:0];
    end else if (v[PROD_W-1]) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return res;
  endfunction

  logic signed [DATA_W-1:0] cr_r, ci_r;
  logic signed [DATA_W-1:0] zr_r, zi_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         limit_r;
  logic signed [PROD_W-1:0] sq_re_r, sq_im_r, cross_r;

  logic [CNT_W-1:0]         cnt_out_r;
  logic                     esc_out_r;
  logic signed [DATA_W-1:0] zr_out_r, zi_out_r;

  logic [PROD_W-1:0]        mag_sum;
  logic signed [PROD_W-1:0] diff;
  logic signed [PROD_W-1:0] re_sum, im_sum;
  logic signed [DATA_W-1:0] zr_nxt, zi_nxt;

  // Escape test and next z from the registered products
  always_comb begin
    mag_sum = $unsigned(sq_re_r) + $unsigned(sq_im_r);
    diff    = sq_re_r - sq_im_r;
    re_sum  = (diff >>> FRAC_BITS) + PROD_W'(cr_r);
    im_sum  = (cross_r >>> (FRAC_BITS - 1)) + PROD_W'(ci_r);
    zr_nxt  = sat_data(re_sum);
    zi_nxt  = sat_data(im_sum);
  end

  assign sts.beyond   = ESC_EN && (mag_sum > ESC_THR);
  assign sts.at_limit = (cnt_r >= limit_r);

  // Load the point, multiply, advance z, capture the result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cr_r    <= c_real;
      ci_r    <= c_imag;
      zr_r    <= '0;
      zi_r    <= '0;
      cnt_r   <= '0;
      limit_r <= limit;
    end else if (cmd.step) begin
      zr_r  <= zr_nxt;
      zi_r  <= zi_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.mul) begin
      sq_re_r <= zr_r * zr_r;
      sq_im_r <= zi_r * zi_r;
      cross_r <= zr_r * zi_r;
    end
    if (cmd.load_out) begin
      cnt_out_r <= cnt_r;
      esc_out_r <= !sts.at_limit;
      zr_out_r  <= zr_r;
      zi_out_r  <= zi_r;
    end
  end

  assign iteration_count = cnt_out_r;
  assign escaped         = esc_out_r;
  assign z_real_final    = zr_out_r;
  assign z_imag_final    = zi_out_r;

endmodule

### rtl/mbe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_ctrl: iteration sequencer
// Accepts a point, alternates multiply and update steps until escape or the
// limit, then hands the result to the output register.
// ----------------------------------------------------------------------------
module mbe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mbe_pkg::mbe_sts_t sts,
  output mbe_pkg::mbe_cmd_t cmd
);
  import mbe_pkg::*;

  mbe_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       finish;

  assign out_free = !out_valid_r || out_ready;
  assign finish   = sts.beyond || sts.at_limit;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_CHK;
      ST_CHK: begin
        if (!finish) begin
          state_nxt = ST_MUL;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_CHK: begin
        cmd.step     = !finish;
        cmd.load_out = finish && out_free;
      end
      ST_HOLD: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  // Result valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/mandelbrot_escape_iteration_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_iteration_top: escape-time iteration for one point
// Iterates z = z*z + c from z = 0 in signed fixed point until |z|^2 > 4 or
// the programmed limit, and returns count, escape flag and final z.
//
//   channel   | direction | handshake          | payload
//   in_pt     | in        | valid/ready        | c_real, c_imag
//   out_res   | out       | valid/ready        | iteration_count, escaped,
//             |           |                    | z_real_final, z_imag_final
//   cfg_*     | in        | APB, pready tied 1 | iteration_limit at 0x0
//
// Each iteration is a multiply step followed by an update step. A new point is
// taken only once the result of the last one has been loaded into the output
// register and the controller is back in idle. A waiting result does not block
// the next point. Reset is synchronous, clears the controller and sets the
// limit to its reset value of 120.
// ----------------------------------------------------------------------------
module mandelbrot_escape_iteration_top #(
  parameter int FRAC_BITS = 28
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mbe_in_if.sink                              in_pt,
  mbe_out_if.source                           out_res,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [mbe_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [mbe_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import mbe_pkg::*;

  logic [CNT_W-1:0] limit_r;
  logic             cfg_wr;
  mbe_cmd_t         cmd;
  mbe_sts_t         sts;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr == ADDR_ITER_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= ITER_LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == ADDR_ITER_LIMIT)
                      ? CFG_DATA_W'(limit_r) : '0;

  // Sequencer
  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pt.valid),
    .in_ready  (in_pt.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic
  mbe_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .c_real          (in_pt.c_real),
    .c_imag          (in_pt.c_imag),
    .limit           (limit_r),
    .cmd             (cmd),
    .sts             (sts),
    .iteration_count (out_res.iteration_count),
    .escaped         (out_res.escaped),
    .z_real_final    (out_res.z_real_final),
    .z_imag_final    (out_res.z_imag_final)
  );

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_res.valid || out_res.ready))
    else $error("result register overwritten before it was taken");

  // A loaded result shows up on the output
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_res.valid)
    else $error("loaded result not presented");

  // Busy after accepting a point
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pt.valid && in_pt.ready) |=> !in_pt.ready)
    else $error("point accepted while still iterating");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the escape-time iteration block
// Drives complex points through the point channel and programs the iteration
// limit over the APB port. A predictor works out each point's iteration count,
// escape flag and final z in 64-bit signed arithmetic at accept time. A
// scoreboard matches every result in order; both channels are throttled in random
// bursts except in the unthrottled last test. The run covers the reset limit,
// directed extremes, limit corner cases and random points, mostly near the set.
// ----------------------------------------------------------------------------
module tb_top;
  import mbe_pkg::*;

  localparam int FRAC_BITS       = 28;
  localparam int ESC_SHIFT       = 2 * FRAC_BITS + 2;
  localparam int Q_ONE           = 1 << FRAC_BITS;
  localparam int WATCHDOG_CYCLES = 400000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int GROUP_ITEMS     = 250;

  typedef struct packed {
    logic [CNT_W-1:0]         count;
    logic                     escaped;
    logic signed [DATA_W-1:0] zr;
    logic signed [DATA_W-1:0] zi;
  } escape_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  mbe_in_if  pt_if ();
  mbe_out_if res_if ();

  escape_result_t   expected_results[$];
  logic [CNT_W-1:0] limit_shadow = ITER_LIMIT_RESET;
  int               idle_pct     = 0;
  int               stall_left   = 0;
  int               quiet_cycles = 0;
  int               mismatches   = 0;

  mandelbrot_escape_iteration_top #(
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pt       (pt_if),
    .out_res     (res_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // Clamp to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] clamp_q(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[DATA_W-1:0];
  endfunction

  // Iterate z = z*z + c from zero under the current limit
  function automatic escape_result_t iterate_point(input logic signed [DATA_W-1:0] cr,
                                                   input logic signed [DATA_W-1:0] ci);
    longint         zr;
    longint         zi;
    longint         re;
    longint         im;
    logic [63:0]    mag;
    int unsigned    n;
    escape_result_t r;
    zr = 0;
    zi = 0;
    n  = 0;
    while (1) begin
      mag = 64'(zr * zr) + 64'(zi * zi);
      if (n >= limit_shadow) break;
      if (ESC_SHIFT <= 63 && mag > (64'd1 << ESC_SHIFT)) break;
      // arithmetic shift on a signed value rounds towards minus infinity
      re = ((zr * zr - zi * zi) >>> FRAC_BITS) + longint'(cr);
      im = ((zr * zi) >>> (FRAC_BITS - 1)) + longint'(ci);
      zr = clamp_q(re);
      zi = clamp_q(im);
      n++;
    end
    r.count   = n[CNT_W-1:0];
    r.escaped = (n < limit_shadow);
    r.zr      = zr[DATA_W-1:0];
    r.zi      = zi[DATA_W-1:0];
    return r;
  endfunction

  // Mostly points near the set, some in a wider square, the rest anywhere
  function automatic void pick_point(output logic [DATA_W-1:0] cr,
                                     output logic [DATA_W-1:0] ci);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) begin
      cr = $urandom_range(0, 3 * Q_ONE) - (9 * (Q_ONE / 4));
      ci = $urandom_range(0, 3 * Q_ONE) - (3 * Q_ONE / 2);
    end else if (sel < 85) begin
      cr = $urandom_range(0, 4 * Q_ONE) - 2 * Q_ONE;
      ci = $urandom_range(0, 4 * Q_ONE) - 2 * Q_ONE;
    end else begin
      cr = $urandom;
      ci = $urandom;
    end
  endfunction

  function automatic void note_mismatch(input string field, input longint want,
                                        input longint got);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
  endfunction

  // Send one point, hold it until taken, then queue its prediction
  task automatic send_point(input logic [DATA_W-1:0] cr, input logic [DATA_W-1:0] ci);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 18);
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_if.valid  <= 1'b1;
    pt_if.c_real <= cr;
    pt_if.c_imag <= ci;
    @(posedge clk);
    while (!pt_if.ready) @(posedge clk);
    expected_results.push_back(iterate_point(cr, ci));
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    pt_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic [CNT_W-1:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_ITER_LIMIT;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[CNT_W-1:0] !== want)
      note_mismatch("iteration_limit readback", want, cfg_prdata[CNT_W-1:0]);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write the limit, mirror it and read it back
  task automatic program_limit(input logic [CFG_DATA_W-1:0] word);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_ITER_LIMIT;
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    limit_shadow = word[CNT_W-1:0];
    @(posedge clk);
    cfg_read_check(limit_shadow);
  endtask

  task automatic test_reset_limit();
    cfg_read_check(ITER_LIMIT_RESET);
  endtask

  // Field extremes, points inside, on the boundary and escaping at once
  task automatic test_directed_points();
    idle_pct = 30;
    send_point(32'h0, 32'h0);
    send_point(-2 * Q_ONE, 32'h0);
    send_point(2 * Q_ONE, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(Q_ONE / 4, 32'h0);
    send_point(-Q_ONE, 32'h0);
    send_point(32'h0, Q_ONE);
    send_point(-3 * Q_ONE / 4, Q_ONE / 10);
    send_point(32'hFFFF_FFFF, 32'h0000_0001);
    drain();
  endtask

  // Zero limit, single step, escape on the last step, masking, largest limit
  task automatic test_limit_extremes();
    idle_pct = 20;
    program_limit(32'd0);
    send_point(32'h0, 32'h0);
    send_point(2 * Q_ONE, 32'h0);
    drain();
    program_limit(32'd1);
    send_point(Q_ONE / 4, Q_ONE);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    program_limit(32'd2);
    send_point(2 * Q_ONE, 32'h0);
    drain();
    program_limit(32'd3);
    send_point(2 * Q_ONE, 32'h0);
    drain();
    // upper data bits carry no meaning for a 16-bit register
    program_limit(32'hABCD_0010);
    send_point(Q_ONE / 2, Q_ONE / 2);
    drain();
    program_limit(32'h0000_FFFF);
    send_point(32'h7FFF_FFFF, 32'h0);
    send_point(Q_ONE / 2, Q_ONE / 2);
    send_point(32'h0, 32'h0);
    drain();
  endtask

  // Groups of random points, each under its own limit and throttling
  task automatic test_random_points();
    logic [DATA_W-1:0] cr;
    logic [DATA_W-1:0] ci;
    for (int g = 0; g < 5; g++) begin
      case (g)
        0: program_limit(32'(ITER_LIMIT_RESET));
        1: program_limit($urandom_range(1, 16));
        2: program_limit($urandom_range(17, 64));
        3: program_limit($urandom_range(65, 255));
        default: program_limit($urandom_range(1, 64));
      endcase
      case ($urandom_range(3))
        0: idle_pct = 0;
        1: idle_pct = 20;
        2: idle_pct = 45;
        default: idle_pct = 70;
      endcase
      for (int k = 0; k < GROUP_ITEMS; k++) begin
        pick_point(cr, ci);
        send_point(cr, ci);
      end
      drain();
    end
  endtask

  // Back-to-back points with both sides always willing
  task automatic test_unthrottled_tail();
    logic [DATA_W-1:0] cr;
    logic [DATA_W-1:0] ci;
    idle_pct = 0;
    program_limit($urandom_range(1, 48));
    for (int k = 0; k < GROUP_ITEMS; k++) begin
      pick_point(cr, ci);
      send_point(cr, ci);
    end
    drain();
  endtask

  // Result side throttling
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(99) < idle_pct / 3) begin
      stall_left   <= $urandom_range(0, 17);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Match each result against the oldest prediction
  always @(posedge clk) begin
    escape_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unrequested result count", 0, res_if.iteration_count);
      end else begin
        want = expected_results.pop_front();
        if (res_if.iteration_count !== want.count)
          note_mismatch("iteration_count", want.count, res_if.iteration_count);
        if (res_if.escaped !== want.escaped)
          note_mismatch("escaped", want.escaped, res_if.escaped);
        if (res_if.z_real_final !== want.zr)
          note_mismatch("z_real_final", want.zr, res_if.z_real_final);
        if (res_if.z_imag_final !== want.zi)
          note_mismatch("z_imag_final", want.zi, res_if.z_imag_final);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = ADDR_ITER_LIMIT;
    cfg_pwdata   = '0;
    pt_if.valid  = 1'b0;
    pt_if.c_real = '0;
    pt_if.c_imag = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_limit();
    test_directed_points();
    test_limit_extremes();
    test_random_points();
    test_unthrottled_tail();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
